// File: hdl/xtea_block_cipher_defines.svh
// Assertion macros used by the top-level cipher RTL.
`ifndef XTEA_BLOCK_CIPHER_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_DEFINES_SVH

// Implication checked outside reset.
`define XTEA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xtea check failed");

// Next-cycle implication, also checked around reset.
`define XTEA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("xtea check failed");

`endif

// File: hdl/xtea_pkg.sv
// Shared types, constants and round function for the XTEA pipeline.
package xtea_pkg;

  localparam int WORD_W       = 32;
  localparam int KEY_WORDS    = 4;
  localparam int KEY_SEL_W    = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int ROUNDS_DFLT  = 32;
  localparam int MIX_SHL      = 4;
  localparam int MIX_SHR      = 5;
  localparam int KEY_SHIFT    = 11;
  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;

  // command codes
  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [KEY_WORDS-1:0] key_set_t;

  typedef struct packed {
    logic  cmd;
    word_t hi;
    word_t lo;
  } blk_t;

  function automatic word_t mix(input word_t x, input word_t sum, input word_t key);
    word_t f;
    f = ((x << MIX_SHL) ^ (x >> MIX_SHR)) + x;
    return f ^ (sum + key);
  endfunction

endpackage

// File: hdl/xtea_key_regs.sv
// Key register file written through the configuration channel.
module xtea_key_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0]        cfg_data,
  output xtea_pkg::key_set_t                 keys
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        xtea_pkg::REG_KEY0: keys[0] <= cfg_data;
        xtea_pkg::REG_KEY1: keys[1] <= cfg_data;
        xtea_pkg::REG_KEY2: keys[2] <= cfg_data;
        xtea_pkg::REG_KEY3: keys[3] <= cfg_data;
        default: ; // out-of-range index: ignored
      endcase
    end
  end

endmodule

// File: hdl/xtea_half_round.sv
// One registered XTEA half round; round sum and key pick are fixed per stage and command.
module xtea_half_round #(
  parameter int STAGE  = 0,
  parameter int ROUNDS = xtea_pkg::ROUNDS_DFLT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  xtea_pkg::blk_t     in_blk,
  output logic               out_valid,
  input  logic               out_ready,
  output xtea_pkg::blk_t     out_blk,
  input  xtea_pkg::key_set_t keys
);

  localparam int  RND    = STAGE / 2;
  localparam bit  IS_ODD = (STAGE % 2) == 1;
  // encrypt: sum after r or r+1 delta steps; decrypt counts down from ROUNDS
  localparam longint unsigned ENC_MULT = IS_ODD ? RND + 1 : RND;
  localparam longint unsigned DEC_MULT = IS_ODD ? ROUNDS - RND - 1 : ROUNDS - RND;
  localparam logic [63:0] ENC_PROD = 64'(ENC_MULT) * 64'(xtea_pkg::DELTA);
  localparam logic [63:0] DEC_PROD = 64'(DEC_MULT) * 64'(xtea_pkg::DELTA);
  localparam xtea_pkg::word_t ENC_SUM = ENC_PROD[xtea_pkg::WORD_W-1:0];
  localparam xtea_pkg::word_t DEC_SUM = DEC_PROD[xtea_pkg::WORD_W-1:0];
  localparam xtea_pkg::word_t ENC_KSH = ENC_SUM >> xtea_pkg::KEY_SHIFT;
  localparam xtea_pkg::word_t DEC_KSH = DEC_SUM >> xtea_pkg::KEY_SHIFT;
  localparam logic [xtea_pkg::KEY_SEL_W-1:0] ENC_KSEL =
    IS_ODD ? ENC_KSH[xtea_pkg::KEY_SEL_W-1:0] : ENC_SUM[xtea_pkg::KEY_SEL_W-1:0];
  localparam logic [xtea_pkg::KEY_SEL_W-1:0] DEC_KSEL =
    IS_ODD ? DEC_SUM[xtea_pkg::KEY_SEL_W-1:0] : DEC_KSH[xtea_pkg::KEY_SEL_W-1:0];

  logic               is_dec;
  logic               upd_hi;
  xtea_pkg::word_t    sum;
  xtea_pkg::word_t    key;
  xtea_pkg::word_t    src;
  xtea_pkg::word_t    dst;
  xtea_pkg::word_t    f;
  xtea_pkg::word_t    res;
  xtea_pkg::blk_t     blk_next;

  always_comb begin
    is_dec = (in_blk.cmd == xtea_pkg::CMD_DEC);
    // encrypt even / decrypt odd update the high half
    upd_hi = (is_dec == IS_ODD);
    sum    = is_dec ? DEC_SUM : ENC_SUM;
    key    = keys[is_dec ? DEC_KSEL : ENC_KSEL];
    src    = upd_hi ? in_blk.lo : in_blk.hi;
    dst    = upd_hi ? in_blk.hi : in_blk.lo;
    f      = xtea_pkg::mix(src, sum, key);
    res    = is_dec ? dst - f : dst + f;
    blk_next = in_blk;
    if (upd_hi) begin
      blk_next.hi = res;
    end else begin
      blk_next.lo = res;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_blk <= blk_next;
    end
  end

endmodule

// File: hdl/xtea_block_cipher.sv
// XTEA block cipher; each of the 2*ROUNDS stages holds one half round.
// Throughput one word per cycle while the output is not stalled by m_tready.
// Stage ready is !valid || downstream ready, so bubbles collapse; with the output
// blocked, input is still taken until every stage holds a word. rst (synchronous)
// clears all stage valids and the four key words to zero; data registers are not reset.
`include "xtea_block_cipher_defines.svh"

module xtea_block_cipher #(
  parameter int ROUNDS = xtea_pkg::ROUNDS_DFLT
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [63:0]                    s_tdata,   // [31:0] block_high, [63:32] block_low
  input  logic                           s_tuser,   // [0] cmd
  // output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [63:0]                    m_tdata,   // [31:0] result_high, [63:32] result_low
  // key configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0]    cfg_data
);

  localparam int STAGES = 2 * ROUNDS;

  xtea_pkg::key_set_t keys;
  xtea_pkg::blk_t     blk   [STAGES+1];
  logic               vld   [STAGES+1];
  logic               rdy   [STAGES+1];

  // Change key words only with the pipeline empty (not enforced); stages read them live.
  xtea_key_regs u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys)
  );

  // Stage 0 input is the slave port; slot STAGES is the master port.
  assign vld[0]     = s_tvalid;
  assign s_tready   = rdy[0];
  assign blk[0].cmd = s_tuser;
  assign blk[0].hi  = s_tdata[31:0];
  assign blk[0].lo  = s_tdata[63:32];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    xtea_half_round #(
      .STAGE  (i),
      .ROUNDS (ROUNDS)
    ) u_half (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_blk    (blk[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_blk   (blk[i+1]),
      .keys      (keys)
    );
  end

  assign rdy[STAGES] = m_tready;
  assign m_tvalid    = vld[STAGES];
  assign m_tdata     = {blk[STAGES].lo, blk[STAGES].hi};

  // A taken input word is in the first stage next cycle.
  `XTEA_ASSERT_NXT(a_enter, !rst && s_tvalid && s_tready, rst || vld[1])
  // A ready sink lets the whole pipe advance, so the input is ready too.
  `XTEA_ASSERT_IMP(a_flow, m_tready, s_tready)
  // Reset empties the pipe.
  `XTEA_ASSERT_NXT(a_reset, rst, !m_tvalid)

endmodule
